// File: design/wlcm_pkg.sv
// ----------------------------------------------------------------------------
// Link connection manager package
// Shared types, codes, reset values and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package wlcm_pkg;

  localparam int unsigned SlotCount = 4;
  localparam int unsigned SlotW     = 2;
  localparam int unsigned OpW       = 4;
  localparam int unsigned RawSlotW  = 8;
  localparam int unsigned CmdW      = 8;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned RetryW    = 4;
  localparam int unsigned ActW      = 10;
  localparam int unsigned LinkW     = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // Event codes.
  localparam logic [OpW-1:0] OpTick       = 4'd0;
  localparam logic [OpW-1:0] OpStartup    = 4'd1;
  localparam logic [OpW-1:0] OpConnect    = 4'd2;
  localparam logic [OpW-1:0] OpBroadcast  = 4'd3;
  localparam logic [OpW-1:0] OpPress      = 4'd4;
  localparam logic [OpW-1:0] OpRelease    = 4'd5;
  localparam logic [OpW-1:0] OpAck        = 4'd6;
  localparam logic [OpW-1:0] OpHandshake  = 4'd7;
  localparam logic [OpW-1:0] OpDisconnect = 4'd8;
  localparam logic [OpW-1:0] OpUnpair     = 4'd9;

  // Acknowledged command codes.
  localparam logic [CmdW-1:0] CmdBroadcast = 8'h01;
  localparam logic [CmdW-1:0] CmdConnect   = 8'h04;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHoldTime     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartupDelay = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSwitchDelay  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHsTimeout    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCmdTimeout   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRetryLimit   = 3'd5;

  localparam logic [DelayW-1:0] HoldTimeRst     = 16'd2000;
  localparam logic [DelayW-1:0] StartupDelayRst = 16'd1000;
  localparam logic [DelayW-1:0] SwitchDelayRst  = 16'd300;
  localparam logic [DelayW-1:0] HsTimeoutRst    = 16'd5000;
  localparam logic [DelayW-1:0] CmdTimeoutRst   = 16'd500;
  localparam logic [RetryW-1:0] RetryLimitRst   = 4'd3;

  // Action mask bits.
  localparam logic [ActW-1:0] ActUsb       = 10'h001;
  localparam logic [ActW-1:0] ActWireless  = 10'h002;
  localparam logic [ActW-1:0] ActBroadcast = 10'h004;
  localparam logic [ActW-1:0] ActConnect   = 10'h008;
  localparam logic [ActW-1:0] ActSlotState = 10'h010;
  localparam logic [ActW-1:0] ActWakeup    = 10'h020;
  localparam logic [ActW-1:0] ActUnpair    = 10'h040;
  localparam logic [ActW-1:0] ActFailure   = 10'h080;
  localparam logic [ActW-1:0] ActSave      = 10'h100;
  localparam logic [ActW-1:0] ActClear     = 10'h200;

  typedef enum logic [LinkW-1:0] {
    LinkUsb       = 3'd0,
    LinkPassive   = 3'd1,
    LinkWaitBcast = 3'd2,
    LinkWaitConn  = 3'd3,
    LinkWaitHs    = 3'd4,
    LinkActive    = 3'd5
  } link_state_e;

  typedef struct packed {
    logic [OpW-1:0]      opcode;
    logic [RawSlotW-1:0] slot;
    logic [CmdW-1:0]     command;
    logic [TimeW-1:0]    now;
  } wlcm_event_t;

  typedef struct packed {
    logic [ActW-1:0]  actions;
    logic [LinkW-1:0] link_state;
    logic [SlotW-1:0] current_slot;
    logic             slot_state_broadcast;
    logic             route_requested;
    logic             operation_pending;
  } wlcm_result_t;

  typedef struct packed {
    link_state_e       link_mode;
    logic [SlotW-1:0]  chosen_slot;
    logic              startup_valid;
    logic [SlotW-1:0]  startup_num;
    logic              held_valid;
    logic [SlotW-1:0]  held_num;
    logic              held_bcast;
    logic              pend_valid;
    logic [SlotW-1:0]  pend_num;
    logic              pend_bcast;
    logic              ss_bcast;
    logic              hs_to_on;
    logic              recovery_used;
    logic [RetryW-1:0] retry_cnt;
    logic [TimeW-1:0]  cmd_stamp;
    logic [TimeW-1:0]  hs_stamp;
    logic [TimeW-1:0]  startup_stamp;
    logic [TimeW-1:0]  hold_stamp;
    logic [TimeW-1:0]  pend_stamp;
  } wlcm_state_t;

  localparam wlcm_state_t StateRst = '{
    link_mode:     LinkUsb,
    chosen_slot:   '0,
    startup_valid: 1'b0,
    startup_num:   '0,
    held_valid:    1'b0,
    held_num:      '0,
    held_bcast:    1'b0,
    pend_valid:    1'b0,
    pend_num:      '0,
    pend_bcast:    1'b0,
    ss_bcast:      1'b0,
    hs_to_on:      1'b0,
    recovery_used: 1'b0,
    retry_cnt:     '0,
    cmd_stamp:     '0,
    hs_stamp:      '0,
    startup_stamp: '0,
    hold_stamp:    '0,
    pend_stamp:    '0
  };

  // Time since a stamp, modulo the stamp width, against a 16-bit limit.
  function automatic logic f_elapsed(logic [TimeW-1:0] now, logic [TimeW-1:0] stamp,
                                     logic [DelayW-1:0] lim);
    logic [TimeW-1:0] diff;
    diff = now - stamp;
    return diff >= {{(TimeW-DelayW){1'b0}}, lim};
  endfunction

  function automatic logic f_op_pending(link_state_e m);
    return (m == LinkWaitBcast) || (m == LinkWaitConn) || (m == LinkWaitHs);
  endfunction

endpackage

`default_nettype wire

// File: design/wlcm_ifs.sv
// ----------------------------------------------------------------------------
// Link connection manager channels
// Valid/ready interfaces for the event and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface wlcm_evt_if;
  import wlcm_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic [RawSlotW-1:0] slot;
  logic [CmdW-1:0]     command;
  logic [TimeW-1:0]    now;

  modport source (output valid, opcode, slot, command, now, input ready);
  modport sink (input valid, opcode, slot, command, now, output ready);
endinterface

interface wlcm_res_if;
  import wlcm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ActW-1:0]  actions;
  logic [LinkW-1:0] link_state;
  logic [SlotW-1:0] current_slot;
  logic             slot_state_broadcast;
  logic             route_requested;
  logic             operation_pending;

  modport source (output valid, actions, link_state, current_slot, slot_state_broadcast,
                  route_requested, operation_pending, input ready);
  modport sink (input valid, actions, link_state, current_slot, slot_state_broadcast,
                route_requested, operation_pending, output ready);
endinterface

`default_nettype wire

// File: design/wlcm_in_stage.sv
// ----------------------------------------------------------------------------
// Link connection manager input register
// Holds one accepted event until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wlcm_in_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  wlcm_evt_if.sink             evt_i,
  input  wire                  take_i,
  output logic                 vld_o,
  output wlcm_pkg::wlcm_event_t evt_o
);
  import wlcm_pkg::*;

  logic        vld_q, vld_d;
  wlcm_event_t evt_q;
  logic        accept;

  // A new event may enter whenever the slot is empty or is being drained.
  assign evt_i.ready = !vld_q || take_i;
  assign accept      = evt_i.valid && evt_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      evt_q <= '{opcode: evt_i.opcode, slot: evt_i.slot, command: evt_i.command,
                 now: evt_i.now};
    end
  end

  assign vld_o = vld_q;
  assign evt_o = evt_q;

endmodule

`default_nettype wire

// File: design/wlcm_core.sv
// ----------------------------------------------------------------------------
// Link connection manager core
// Timing registers, link state and the per-event next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module wlcm_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [wlcm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [wlcm_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire                               fire_i,
  input  wire wlcm_pkg::wlcm_event_t        evt_i,
  output wlcm_pkg::wlcm_result_t            res_o
);
  import wlcm_pkg::*;

  logic [DelayW-1:0] hold_time_q, startup_delay_q, switch_delay_q;
  logic [DelayW-1:0] hs_timeout_q, cmd_timeout_q;
  logic [RetryW-1:0] retry_limit_q;

  wlcm_state_t st_q, st_d;
  logic [ActW-1:0] act;

  function automatic wlcm_state_t f_begin_bcast(wlcm_state_t s_in, logic [SlotW-1:0] slot,
                                                logic with_ss, logic hs_to,
                                                logic [TimeW-1:0] now);
    wlcm_state_t s;
    s               = s_in;
    s.link_mode     = LinkWaitBcast;
    s.startup_valid = 1'b0;
    s.chosen_slot   = slot;
    s.ss_bcast      = with_ss;
    s.hs_to_on      = hs_to;
    s.retry_cnt     = '0;
    s.cmd_stamp     = now;
    return s;
  endfunction

  function automatic wlcm_state_t f_begin_conn(wlcm_state_t s_in, logic [SlotW-1:0] slot,
                                               logic [TimeW-1:0] now);
    wlcm_state_t s;
    s               = s_in;
    s.link_mode     = LinkWaitConn;
    s.startup_valid = 1'b0;
    s.chosen_slot   = slot;
    s.ss_bcast      = 1'b0;
    s.hs_to_on      = 1'b1;
    s.retry_cnt     = '0;
    s.cmd_stamp     = now;
    return s;
  endfunction

  function automatic wlcm_state_t f_queue(wlcm_state_t s_in, logic [SlotW-1:0] slot,
                                          logic bcast, logic [TimeW-1:0] now);
    wlcm_state_t s;
    s            = s_in;
    s.link_mode  = LinkUsb;
    s.retry_cnt  = '0;
    s.hs_to_on   = 1'b0;
    s.pend_valid = 1'b1;
    s.pend_num   = slot;
    s.pend_bcast = bcast;
    s.pend_stamp = now;
    return s;
  endfunction

  function automatic wlcm_state_t f_connect(wlcm_state_t s_in, logic [SlotW-1:0] slot,
                                            logic [TimeW-1:0] now, output logic [ActW-1:0] a);
    wlcm_state_t s;
    s               = s_in;
    s.startup_valid = 1'b0;
    if (s.link_mode == LinkPassive) begin
      s.link_mode = LinkUsb;
    end
    if (s.pend_valid) begin
      s = f_queue(s, slot, 1'b0, now);
      a = ActUsb;
    end else if (f_op_pending(s.link_mode)) begin
      if (s.chosen_slot == slot) begin
        s.pend_valid = 1'b0;
      end else begin
        s = f_queue(s, slot, 1'b0, now);
      end
      a = ActUsb;
    end else begin
      s.pend_valid    = 1'b0;
      s.recovery_used = 1'b0;
      s = f_begin_conn(s, slot, now);
      a = ActUsb | ActSlotState | ActConnect;
    end
    return s;
  endfunction

  function automatic wlcm_state_t f_broadcast(wlcm_state_t s_in, logic [SlotW-1:0] slot,
                                              logic [TimeW-1:0] now, output logic [ActW-1:0] a);
    wlcm_state_t s;
    s               = s_in;
    s.startup_valid = 1'b0;
    if (s.link_mode == LinkPassive) begin
      s.link_mode = LinkUsb;
    end
    if (s.pend_valid || f_op_pending(s.link_mode)) begin
      s = f_queue(s, slot, 1'b1, now);
      a = ActUsb;
    end else begin
      s.recovery_used = 1'b0;
      s = f_begin_bcast(s, slot, 1'b1, 1'b0, now);
      a = ActUsb | ActBroadcast | ActSlotState;
    end
    return s;
  endfunction

  function automatic wlcm_state_t f_disconnect(wlcm_state_t s_in);
    wlcm_state_t s;
    s               = s_in;
    s.retry_cnt     = '0;
    s.recovery_used = 1'b0;
    s.hs_to_on      = 1'b0;
    s.startup_valid = 1'b0;
    s.held_valid    = 1'b0;
    s.held_bcast    = 1'b0;
    s.pend_valid    = 1'b0;
    s.link_mode     = LinkUsb;
    return s;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q     <= HoldTimeRst;
      startup_delay_q <= StartupDelayRst;
      switch_delay_q  <= SwitchDelayRst;
      hs_timeout_q    <= HsTimeoutRst;
      cmd_timeout_q   <= CmdTimeoutRst;
      retry_limit_q   <= RetryLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHoldTime:     hold_time_q     <= cfg_data_i;
        CfgStartupDelay: startup_delay_q <= cfg_data_i;
        CfgSwitchDelay:  switch_delay_q  <= cfg_data_i;
        CfgHsTimeout:    hs_timeout_q    <= cfg_data_i;
        CfgCmdTimeout:   cmd_timeout_q   <= cfg_data_i;
        CfgRetryLimit:   retry_limit_q   <= cfg_data_i[RetryW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wlcm_state_t      s;
    logic [ActW-1:0]  a;
    logic [SlotW-1:0] slot_c;
    logic [SlotW-1:0] pn;
    logic             pb;
    logic             in_range;

    s        = st_q;
    act      = '0;
    a        = '0;
    in_range = evt_i.slot <= RawSlotW'(SlotCount - 1);
    slot_c   = in_range ? evt_i.slot[SlotW-1:0] : SlotW'(SlotCount - 1);
    pn       = '0;
    pb       = 1'b0;

    unique case (evt_i.opcode)
      OpTick: begin
        if (s.held_valid && !s.held_bcast &&
            f_elapsed(evt_i.now, s.hold_stamp, hold_time_q)) begin
          s.held_bcast = 1'b1;
          s   = f_broadcast(s, s.held_num, evt_i.now, a);
          act = act | a;
        end
        if (s.startup_valid && f_elapsed(evt_i.now, s.startup_stamp, startup_delay_q)) begin
          s   = f_begin_bcast(s, s.startup_num, 1'b0, 1'b1, evt_i.now);
          act = act | ActUsb | ActBroadcast;
        end
        if (s.pend_valid && f_elapsed(evt_i.now, s.pend_stamp, switch_delay_q)) begin
          pn              = s.pend_num;
          pb              = s.pend_bcast;
          s.pend_valid    = 1'b0;
          s.hs_to_on      = 1'b0;
          s.recovery_used = 1'b0;
          s.link_mode     = LinkUsb;
          if (pb) begin
            s   = f_begin_bcast(s, pn, 1'b1, 1'b0, evt_i.now);
            act = act | ActUsb | ActBroadcast | ActSlotState;
          end else begin
            s   = f_begin_conn(s, pn, evt_i.now);
            act = act | ActUsb | ActSlotState | ActConnect;
          end
        end
        if (s.link_mode == LinkWaitHs) begin
          if (s.hs_to_on && f_elapsed(evt_i.now, s.hs_stamp, hs_timeout_q)) begin
            s.link_mode = LinkUsb;
            s.hs_to_on  = 1'b0;
            act         = act | ActUsb;
            // One wakeup recovery is tried before the link is reported failed.
            if (!s.recovery_used) begin
              s.recovery_used = 1'b1;
              s.startup_valid = 1'b1;
              s.startup_num   = s.chosen_slot;
              s.startup_stamp = evt_i.now;
              act             = act | ActWakeup;
            end else begin
              act = act | ActFailure;
            end
          end
        end else if ((s.link_mode == LinkWaitBcast || s.link_mode == LinkWaitConn) &&
                     f_elapsed(evt_i.now, s.cmd_stamp, cmd_timeout_q)) begin
          if (s.retry_cnt >= retry_limit_q) begin
            s.hs_stamp  = evt_i.now;
            s.link_mode = LinkWaitHs;
          end else begin
            s.retry_cnt = s.retry_cnt + RetryW'(1);
            s.cmd_stamp = evt_i.now;
            act = act | ((s.link_mode == LinkWaitBcast) ? ActBroadcast : ActConnect);
          end
        end
      end
      OpStartup: begin
        s = StateRst;
        if (in_range) begin
          s.startup_valid = 1'b1;
          s.startup_num   = evt_i.slot[SlotW-1:0];
          s.chosen_slot   = evt_i.slot[SlotW-1:0];
          s.startup_stamp = evt_i.now;
          s.link_mode     = LinkPassive;
        end
        act = ActWakeup;
      end
      OpConnect: begin
        s   = f_connect(s, slot_c, evt_i.now, a);
        act = a;
      end
      OpBroadcast: begin
        s   = f_broadcast(s, slot_c, evt_i.now, a);
        act = a;
      end
      OpPress: begin
        s.startup_valid = 1'b0;
        if (s.link_mode == LinkPassive) begin
          s.link_mode = LinkUsb;
        end
        s.held_valid = 1'b1;
        s.held_num   = slot_c;
        s.held_bcast = 1'b0;
        s.hold_stamp = evt_i.now;
      end
      OpRelease: begin
        if (s.held_valid && s.held_num == slot_c) begin
          pb           = s.held_bcast;
          s.held_valid = 1'b0;
          s.held_bcast = 1'b0;
          // A short press connects; a long one has already issued or queued a broadcast.
          if (!pb) begin
            s   = f_connect(s, slot_c, evt_i.now, a);
            act = a;
          end
        end
      end
      OpAck: begin
        if ((evt_i.command == CmdBroadcast && s.link_mode == LinkWaitBcast) ||
            (evt_i.command == CmdConnect && s.link_mode == LinkWaitConn)) begin
          s.retry_cnt = '0;
          s.hs_stamp  = evt_i.now;
          s.link_mode = LinkWaitHs;
        end
      end
      OpHandshake: begin
        if (s.link_mode != LinkUsb) begin
          s.startup_valid = 1'b0;
          s.retry_cnt     = '0;
          s.recovery_used = 1'b0;
          s.hs_to_on      = 1'b0;
          s.link_mode     = LinkActive;
          act             = ActWireless | ActSave;
        end
      end
      OpDisconnect: begin
        s   = f_disconnect(s);
        act = ActUsb | ActClear;
      end
      OpUnpair: begin
        s   = f_disconnect(s);
        act = ActUnpair | ActUsb | ActClear;
      end
      default: ;
    endcase

    st_d = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateRst;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  assign res_o = '{
    actions:              act,
    link_state:           st_d.link_mode,
    current_slot:         st_d.chosen_slot,
    slot_state_broadcast: st_d.ss_bcast,
    route_requested:      st_d.link_mode != LinkUsb,
    operation_pending:    f_op_pending(st_d.link_mode)
  };

endmodule

`default_nettype wire

// File: design/wlcm_out_stage.sv
// ----------------------------------------------------------------------------
// Link connection manager result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wlcm_out_stage (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         load_i,
  input  wire wlcm_pkg::wlcm_result_t res_i,
  output logic                        free_o,
  wlcm_res_if.source                  res_o
);
  import wlcm_pkg::*;

  logic         vld_q, vld_d;
  wlcm_result_t res_q;

  // The register can take a new result when empty or when its transfer completes.
  assign free_o = !vld_q || res_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (res_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid                = vld_q;
  assign res_o.actions              = res_q.actions;
  assign res_o.link_state           = res_q.link_state;
  assign res_o.current_slot         = res_q.current_slot;
  assign res_o.slot_state_broadcast = res_q.slot_state_broadcast;
  assign res_o.route_requested      = res_q.route_requested;
  assign res_o.operation_pending    = res_q.operation_pending;

endmodule

`default_nettype wire

// File: design/wireless_link_connection_manager.sv
// A result is offered once its event has passed the input register and then the result
// register; one event per cycle is taken while the result side is not stalled, since the
// link state is updated combinationally between the two registers.
// Reset clears the link state and loads the default timing values; no clearing pass.
// ----------------------------------------------------------------------------
// Wireless link connection manager
// Link state machine with slot selection, command retries and wakeup recovery.
// ----------------------------------------------------------------------------
`default_nettype none

module wireless_link_connection_manager (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [wlcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [wlcm_pkg::CfgDataW-1:0] cfg_data_i,
  wlcm_evt_if.sink                     evt_i,
  wlcm_res_if.source                   res_o
);
  import wlcm_pkg::*;

  logic         in_vld;
  wlcm_event_t  evt;
  wlcm_result_t res;
  logic         out_free;
  logic         fire;

  assign fire = in_vld && out_free;

  wlcm_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .take_i (fire),
    .vld_o  (in_vld),
    .evt_o  (evt)
  );

  wlcm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .evt_i      (evt),
    .res_o      (res)
  );

  wlcm_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

`ifndef ASSERT_OFF
  // A held event is never dropped while the result side is stalled.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld && res_o.valid && !res_o.ready) |=> in_vld)
    else $error("held event lost while result stalled");

  // Every processed event leaves a result behind.
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_o.valid)
    else $error("processed event produced no result");

  // A pending operation always implies a requested route.
  a_pending_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.operation_pending) |-> res_o.route_requested)
    else $error("operation pending without a requested route");
`endif

endmodule

`default_nettype wire
